>>> src/dwbm_pkg.sv
// shared constants, codes and types of the distance window brightness map
package dwbm_pkg;

    localparam int WINDOW_LEN_DEF  = 10;
    localparam int SAMPLE_BITS_DEF = 10;

    localparam int LIMIT_W    = 10;
    localparam int LEVEL_W    = 7;
    localparam int ACTION_W   = 2;
    localparam int AVG_OUT_W  = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SET    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FAR    = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NEAR   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_LIMIT       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_BRIGHTNESS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_STEP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_CEILING   = 3'd4;

    localparam logic [LIMIT_W-1:0] NEAR_LIMIT_RST      = 10'd20;
    localparam logic [LIMIT_W-1:0] FAR_LIMIT_RST       = 10'd100;
    localparam logic [LEVEL_W-1:0] BASE_BRIGHTNESS_RST = 7'd20;
    localparam logic [LEVEL_W-1:0] LEVEL_STEP_RST      = 7'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_CEILING_RST   = 7'd100;

    typedef struct packed {
        logic [LIMIT_W-1:0] near_limit;
        logic [LIMIT_W-1:0] far_limit;
        logic [LEVEL_W-1:0] base_brightness;
        logic [LEVEL_W-1:0] level_step;
        logic [LEVEL_W-1:0] level_ceiling;
    } cfg_t;

endpackage

>>> src/dwbm_cell.sv
// one cell of the sample window: holds a sample and its filled flag
module dwbm_cell #(
    parameter int SAMPLE_BITS = dwbm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   shift_en,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    input  logic                   in_full,
    output logic [SAMPLE_BITS-1:0] out_sample,
    output logic                   out_full
);

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   full_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else if (shift_en) begin
            full_reg <= in_full;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            sample_reg <= in_sample;
        end
    end

    // an empty cell counts as zero
    assign out_sample = full_reg ? sample_reg : '0;
    assign out_full   = full_reg;

endmodule

>>> src/dwbm_avg.sv
// window average: running sum divided by the window length via reciprocal
module dwbm_avg #(
    parameter int WINDOW_LEN  = dwbm_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = dwbm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [SAMPLE_BITS+$clog2(WINDOW_LEN)-1:0]     in_sum,
    input  logic                                          in_full,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [SAMPLE_BITS-1:0]                        out_avg,
    output logic                                          out_full
);

    localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_LEN);
    localparam int K       = SUM_W;
    localparam int RECIP_W = K + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << K) / WINDOW_LEN);
    localparam logic [SUM_W-1:0]   WLEN  = SUM_W'(WINDOW_LEN);

    logic              va_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  sum_a_reg;
    logic              full_a_reg;
    logic              ready_a;

    logic                   vb_reg;
    logic [SAMPLE_BITS-1:0] avg_reg;
    logic                   full_b_reg;
    logic                   ready_b;

    logic [SUM_W-1:0]   q0;
    logic [2*SUM_W-1:0] qw_full;
    logic [SUM_W-1:0]   qw;
    logic [SUM_W-1:0]   rem;
    logic [SUM_W-1:0]   quot;

    assign ready_b  = !vb_reg || out_ready;
    assign ready_a  = !va_reg || ready_b;
    assign in_ready = ready_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (ready_a) begin
            va_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_a && in_valid) begin
            prod_reg   <= PROD_W'(in_sum) * PROD_W'(RECIP);
            sum_a_reg  <= in_sum;
            full_a_reg <= in_full;
        end
    end

    // estimate is exact or one low
    assign q0      = prod_reg[K +: SUM_W];
    assign qw_full = q0 * WLEN;
    assign qw      = qw_full[SUM_W-1:0];
    assign rem     = sum_a_reg - qw;
    assign quot    = (rem >= WLEN) ? q0 + SUM_W'(1) : q0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (ready_b) begin
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_b && va_reg) begin
            avg_reg    <= quot[SAMPLE_BITS-1:0];
            full_b_reg <= full_a_reg;
        end
    end

    assign out_valid = vb_reg;
    assign out_avg   = avg_reg;
    assign out_full  = full_b_reg;

endmodule

>>> src/dwbm_classify.sv
// classification of the average and brightness computation, output register
module dwbm_classify #(
    parameter int SAMPLE_BITS = dwbm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [SAMPLE_BITS-1:0]            in_avg,
    input  logic                              in_full,
    input  dwbm_pkg::cfg_t                    cfg,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [dwbm_pkg::ACTION_W-1:0]     out_action,
    output logic [dwbm_pkg::LEVEL_W-1:0]      out_brightness,
    output logic                              out_led_lit,
    output logic [dwbm_pkg::AVG_OUT_W-1:0]    out_window_average
);

    localparam int CMP_W = (SAMPLE_BITS > dwbm_pkg::LIMIT_W) ? SAMPLE_BITS
                                                             : dwbm_pkg::LIMIT_W;
    localparam int MUL_W = CMP_W + dwbm_pkg::LEVEL_W;
    localparam int VAL_W = MUL_W + 1;

    logic                             valid_reg;
    logic [dwbm_pkg::ACTION_W-1:0]    action_reg;
    logic [dwbm_pkg::LEVEL_W-1:0]     bright_reg;
    logic                             led_reg;
    logic [dwbm_pkg::AVG_OUT_W-1:0]   avg_reg;

    logic [CMP_W-1:0]              avg_x;
    logic [CMP_W-1:0]              near_x;
    logic [CMP_W-1:0]              far_x;
    logic [CMP_W-1:0]              diff;
    logic [MUL_W-1:0]              prod;
    logic [VAL_W-1:0]              level;
    logic [dwbm_pkg::LEVEL_W-1:0]  level_clamped;
    logic [dwbm_pkg::ACTION_W-1:0] action;
    logic [CMP_W+dwbm_pkg::AVG_OUT_W-1:0] avg_wide;

    assign avg_x  = CMP_W'(in_avg);
    assign near_x = CMP_W'(cfg.near_limit);
    assign far_x  = CMP_W'(cfg.far_limit);
    assign diff   = avg_x - near_x;
    assign prod   = MUL_W'(diff) * MUL_W'(cfg.level_step);
    assign level  = VAL_W'(prod) + VAL_W'(cfg.base_brightness);
    assign level_clamped = (level > VAL_W'(cfg.level_ceiling)) ? cfg.level_ceiling
                                                               : level[dwbm_pkg::LEVEL_W-1:0];
    assign avg_wide = (CMP_W + dwbm_pkg::AVG_OUT_W)'(in_avg);

    always_comb begin
        action = dwbm_pkg::ACT_NONE;
        if (in_full) begin
            if (avg_x > near_x && avg_x < far_x) begin
                action = dwbm_pkg::ACT_SET;
            end else if (avg_x > far_x) begin
                action = dwbm_pkg::ACT_FAR;
            end else if (avg_x < near_x) begin
                action = dwbm_pkg::ACT_NEAR;
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            action_reg <= action;
            bright_reg <= (action == dwbm_pkg::ACT_SET) ? level_clamped : '0;
            led_reg    <= (action == dwbm_pkg::ACT_FAR);
            avg_reg    <= in_full ? avg_wide[dwbm_pkg::AVG_OUT_W-1:0] : '0;
        end
    end

    assign out_valid          = valid_reg;
    assign out_action         = action_reg;
    assign out_brightness     = bright_reg;
    assign out_led_lit        = led_reg;
    assign out_window_average = avg_reg;

endmodule

>>> src/distance_window_brightness_map.sv
// top level of the distance window brightness map
//
// s_ channel: one distance sample per request (s_valid/s_ready).
// m_ channel: exactly one result per sample, in order (m_valid/m_ready):
//   action, brightness, led_lit and the truncated window average.
// cfg channel: register writes by index, always ready; write only when idle.
// The window is a chain of WINDOW_LEN cells that shift on every accepted
// sample; the running sum is updated in the same cycle.
// Each accepted sample passes the sum register, reciprocal multiply, quotient
// correction and output register in order before its result shows on m_.
// Throughput: one sample per cycle while m_ready stays high; every stage holds one
// request and moves on as soon as the next stage has room.
// When m_ready is low the result waits in the output register while the
// earlier stages still fill; s_ready drops only once every stage is full.
// Reset empties the window, clears the sum and all stage valids and loads
// the registers with their defaults; no result is produced until a request
// arrives. Results stay action none until WINDOW_LEN samples have entered.
module distance_window_brightness_map #(
    parameter int WINDOW_LEN  = dwbm_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = dwbm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [SAMPLE_BITS-1:0]             s_distance_sample,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [dwbm_pkg::ACTION_W-1:0]      m_action,
    output logic [dwbm_pkg::LEVEL_W-1:0]       m_brightness,
    output logic                               m_led_lit,
    output logic [dwbm_pkg::AVG_OUT_W-1:0]     m_window_average,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dwbm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dwbm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_LEN);

    dwbm_pkg::cfg_t cfg_reg;

    logic [SAMPLE_BITS-1:0] cell_sample [WINDOW_LEN];
    logic                   cell_full   [WINDOW_LEN];

    logic             s1_valid_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic             accept;
    logic             avg_in_ready;

    logic                   avg_valid;
    logic                   avg_ready;
    logic [SAMPLE_BITS-1:0] avg_value;
    logic                   avg_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.near_limit      <= dwbm_pkg::NEAR_LIMIT_RST;
            cfg_reg.far_limit       <= dwbm_pkg::FAR_LIMIT_RST;
            cfg_reg.base_brightness <= dwbm_pkg::BASE_BRIGHTNESS_RST;
            cfg_reg.level_step      <= dwbm_pkg::LEVEL_STEP_RST;
            cfg_reg.level_ceiling   <= dwbm_pkg::LEVEL_CEILING_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                dwbm_pkg::REG_NEAR_LIMIT: begin
                    cfg_reg.near_limit <= cfg_data[dwbm_pkg::LIMIT_W-1:0];
                end
                dwbm_pkg::REG_FAR_LIMIT: begin
                    cfg_reg.far_limit <= cfg_data[dwbm_pkg::LIMIT_W-1:0];
                end
                dwbm_pkg::REG_BASE_BRIGHTNESS: begin
                    cfg_reg.base_brightness <= cfg_data[dwbm_pkg::LEVEL_W-1:0];
                end
                dwbm_pkg::REG_LEVEL_STEP: begin
                    cfg_reg.level_step <= cfg_data[dwbm_pkg::LEVEL_W-1:0];
                end
                dwbm_pkg::REG_LEVEL_CEILING: begin
                    cfg_reg.level_ceiling <= cfg_data[dwbm_pkg::LEVEL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign s_ready = !s1_valid_reg || avg_in_ready;
    assign accept  = s_valid && s_ready;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_LEN; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                dwbm_cell #(
                    .SAMPLE_BITS(SAMPLE_BITS)
                ) u_cell (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .shift_en  (accept),
                    .in_sample (s_distance_sample),
                    .in_full   (1'b1),
                    .out_sample(cell_sample[gi]),
                    .out_full  (cell_full[gi])
                );
            end else begin : g_body
                dwbm_cell #(
                    .SAMPLE_BITS(SAMPLE_BITS)
                ) u_cell (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .shift_en  (accept),
                    .in_sample (cell_sample[gi-1]),
                    .in_full   (cell_full[gi-1]),
                    .out_sample(cell_sample[gi]),
                    .out_full  (cell_full[gi])
                );
            end
        end
    endgenerate

    // oldest sample leaves the window as the new one enters
    assign sum_next = sum_reg - SUM_W'(cell_sample[WINDOW_LEN-1])
                    + SUM_W'(s_distance_sample);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            sum_reg      <= '0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (accept) begin
                sum_reg <= sum_next;
            end
        end
    end

    dwbm_avg #(
        .WINDOW_LEN (WINDOW_LEN),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_avg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s1_valid_reg),
        .in_ready (avg_in_ready),
        .in_sum   (sum_reg),
        .in_full  (cell_full[WINDOW_LEN-1]),
        .out_valid(avg_valid),
        .out_ready(avg_ready),
        .out_avg  (avg_value),
        .out_full (avg_full)
    );

    dwbm_classify #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_classify (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (avg_valid),
        .in_ready          (avg_ready),
        .in_avg            (avg_value),
        .in_full           (avg_full),
        .cfg               (cfg_reg),
        .out_valid         (m_valid),
        .out_ready         (m_ready),
        .out_action        (m_action),
        .out_brightness    (m_brightness),
        .out_led_lit       (m_led_lit),
        .out_window_average(m_window_average)
    );

endmodule

>>> verif/testbench.sv
// self-checking testbench for the distance window brightness map
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN        = dwbm_pkg::WINDOW_LEN_DEF;
    localparam int SBITS      = dwbm_pkg::SAMPLE_BITS_DEF;
    localparam int LIM_W      = dwbm_pkg::LIMIT_W;
    localparam int LVL_W      = dwbm_pkg::LEVEL_W;
    localparam int ACT_W      = dwbm_pkg::ACTION_W;
    localparam int AVG_W      = dwbm_pkg::AVG_OUT_W;
    localparam int IDX_W      = dwbm_pkg::CFG_IDX_W;
    localparam int DATA_W     = dwbm_pkg::CFG_DATA_W;
    localparam int SAMPLE_MAX = (1 << SBITS) - 1;
    localparam int PAD_W      = DATA_W - LVL_W;
    localparam int IDX_TOP    = (1 << IDX_W) - 1;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [LVL_W-1:0] brightness;
        logic             led_lit;
        logic [AVG_W-1:0] average;
    } light_cmd_t;

    logic              aclk              = 1'b0;
    logic              aresetn           = 1'b0;
    logic              s_valid           = 1'b0;
    logic              s_ready;
    logic [SBITS-1:0]  s_distance_sample = '0;
    logic              m_valid;
    logic              m_ready           = 1'b0;
    logic [ACT_W-1:0]  m_action;
    logic [LVL_W-1:0]  m_brightness;
    logic              m_led_lit;
    logic [AVG_W-1:0]  m_window_average;
    logic              cfg_valid         = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index         = '0;
    logic [DATA_W-1:0] cfg_data          = '0;

    // predicted block state
    logic [SBITS-1:0] ring [WIN];
    int unsigned      wpos;
    bit               filled;
    int unsigned      sum;
    dwbm_pkg::cfg_t   lim;

    light_cmd_t pending_cmds [$];
    int         mismatches  = 0;
    bit         src_idle_on = 1'b1;
    bit         snk_idle_on = 1'b1;
    int         hold_off    = 0;

    distance_window_brightness_map i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_distance_sample (s_distance_sample),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_action          (m_action),
        .m_brightness      (m_brightness),
        .m_led_lit         (m_led_lit),
        .m_window_average  (m_window_average),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic light_cmd_t map_sample(input logic [SBITS-1:0] sample);
        light_cmd_t  cmd;
        int unsigned avg;
        int unsigned level;
        cmd = '0;
        sum = sum - ring[wpos] + sample;
        ring[wpos] = sample;
        wpos = (wpos == WIN - 1) ? 0 : wpos + 1;
        if (wpos == 0) begin
            filled = 1'b1;
        end
        if (filled) begin
            avg = sum / WIN;
            cmd.average = AVG_W'(avg);
            if (avg > lim.near_limit && avg < lim.far_limit) begin
                level = lim.base_brightness + (avg - lim.near_limit) * lim.level_step;
                cmd.action = dwbm_pkg::ACT_SET;
                cmd.brightness = (level > lim.level_ceiling) ? lim.level_ceiling
                                                             : LVL_W'(level);
            end else if (avg > lim.far_limit) begin
                cmd.action = dwbm_pkg::ACT_FAR;
                cmd.led_lit = 1'b1;
            end else if (avg < lim.near_limit) begin
                cmd.action = dwbm_pkg::ACT_NEAR;
            end else begin
                cmd.action = dwbm_pkg::ACT_NONE;
            end
        end
        return cmd;
    endfunction

    // sample that moves the window average to the target, as far as one sample can
    function automatic logic [SBITS-1:0] sample_for_average(input int target);
        int need;
        need = target * WIN + int'($urandom_range(0, WIN - 1)) - (int'(sum) - int'(ring[wpos]));
        if (need < 0) begin
            need = 0;
        end
        if (need > SAMPLE_MAX) begin
            need = SAMPLE_MAX;
        end
        return SBITS'(need);
    endfunction

    function automatic logic [SBITS-1:0] next_sample();
        int pick;
        int target;
        pick = int'($urandom_range(0, 99));
        if (pick < 15) begin
            return $urandom_range(0, 1) ? SBITS'(SAMPLE_MAX) : '0;
        end
        if (pick < 40) begin
            return SBITS'($urandom_range(0, SAMPLE_MAX));
        end
        case ($urandom_range(0, 6))
            0: target = int'(lim.near_limit) - 1;
            1: target = int'(lim.near_limit);
            2: target = int'(lim.near_limit) + 1;
            3: target = int'(lim.far_limit) - 1;
            4: target = int'(lim.far_limit);
            5: target = int'(lim.far_limit) + 1;
            default: target = int'($urandom_range(0, SAMPLE_MAX));
        endcase
        if (target < 0) begin
            target = 0;
        end
        if (target > SAMPLE_MAX) begin
            target = SAMPLE_MAX;
        end
        return sample_for_average(target);
    endfunction

    function automatic int pick_gap(input bit on);
        int r;
        if (!on) begin
            return 0;
        end
        r = int'($urandom_range(0, 99));
        if (r < 60) begin
            return 0;
        end
        if (r < 88) begin
            return int'($urandom_range(1, 3));
        end
        if (r < 97) begin
            return int'($urandom_range(4, 12));
        end
        return int'($urandom_range(20, 40));
    endfunction

    task automatic send_sample(input logic [SBITS-1:0] sample);
        int gap;
        gap = pick_gap(src_idle_on);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_distance_sample = sample;
        do @(posedge aclk); while (!s_ready);
        pending_cmds.push_back(map_sample(sample));
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            dwbm_pkg::REG_NEAR_LIMIT:      lim.near_limit = data[LIM_W-1:0];
            dwbm_pkg::REG_FAR_LIMIT:       lim.far_limit = data[LIM_W-1:0];
            dwbm_pkg::REG_BASE_BRIGHTNESS: lim.base_brightness = data[LVL_W-1:0];
            dwbm_pkg::REG_LEVEL_STEP:      lim.level_step = data[LVL_W-1:0];
            dwbm_pkg::REG_LEVEL_CEILING:   lim.level_ceiling = data[LVL_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid = 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic apply_setting(input dwbm_pkg::cfg_t c);
        logic [IDX_W-1:0] spare;
        settle();
        spare = IDX_W'($urandom_range(int'(dwbm_pkg::REG_LEVEL_CEILING) + 1, IDX_TOP));
        write_reg(dwbm_pkg::REG_NEAR_LIMIT, c.near_limit);
        write_reg(dwbm_pkg::REG_FAR_LIMIT, c.far_limit);
        write_reg(dwbm_pkg::REG_BASE_BRIGHTNESS, {PAD_W'($urandom), c.base_brightness});
        write_reg(dwbm_pkg::REG_LEVEL_STEP, {PAD_W'($urandom), c.level_step});
        write_reg(dwbm_pkg::REG_LEVEL_CEILING, {PAD_W'($urandom), c.level_ceiling});
        write_reg(spare, DATA_W'($urandom));
        cfg_valid = 1'b0;
    endtask

    task automatic test_reset_defaults();
        int warmup [9]  = '{SAMPLE_MAX, 0, 0, 0, 0, 0, 0, 0, 0};
        int targets [10] = '{100, 20, 100, 50, 101, 19, 0, 99, 21, SAMPLE_MAX};
        foreach (warmup[i]) begin
            send_sample(SBITS'(warmup[i]));
        end
        foreach (targets[i]) begin
            send_sample(sample_for_average(targets[i]));
        end
        settle();
    endtask

    task automatic test_settings();
        dwbm_pkg::cfg_t settings [6] = '{
            '{10'd0,    10'd1023, 7'd0,   7'd0,   7'd0},
            '{10'd1023, 10'd1023, 7'd127, 7'd127, 7'd127},
            '{10'd1023, 10'd0,    7'd50,  7'd3,   7'd100},
            '{10'd0,    10'd0,    7'd127, 7'd0,   7'd60},
            '{10'd30,   10'd200,  7'd100, 7'd5,   7'd30},
            '{10'd10,   10'd60,   7'd0,   7'd127, 7'd100}
        };
        foreach (settings[i]) begin
            apply_setting(settings[i]);
            repeat (40) send_sample(next_sample());
        end
        settle();
    endtask

    task automatic test_backpressure();
        src_idle_on = 1'b0;
        hold_off = 80;
        repeat (40) send_sample(next_sample());
        src_idle_on = 1'b1;
        settle();
    endtask

    task automatic test_random();
        dwbm_pkg::cfg_t   c;
        logic [LIM_W-1:0] tmp;
        for (int chunk = 0; chunk < 22; chunk++) begin
            if (chunk % 4 == 1) begin
                c.near_limit = LIM_W'($urandom_range(0, SAMPLE_MAX));
                c.far_limit = LIM_W'($urandom_range(0, SAMPLE_MAX));
                if (c.near_limit > c.far_limit && $urandom_range(0, 4) != 0) begin
                    tmp = c.near_limit;
                    c.near_limit = c.far_limit;
                    c.far_limit = tmp;
                end
                c.base_brightness = LVL_W'($urandom);
                c.level_step = ($urandom_range(0, 3) != 0) ? LVL_W'($urandom_range(0, 8))
                                                           : LVL_W'($urandom);
                c.level_ceiling = LVL_W'($urandom);
                apply_setting(c);
            end
            src_idle_on = ($urandom_range(0, 3) != 0);
            snk_idle_on = ($urandom_range(0, 3) != 0);
            repeat (50) send_sample(next_sample());
        end
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        settle();
    endtask

    initial begin : sink
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (hold_off > 0) begin
                m_ready = 1'b0;
                hold_off--;
            end else if (stall > 0) begin
                m_ready = 1'b0;
                stall--;
            end else begin
                m_ready = 1'b1;
                stall = pick_gap(snk_idle_on);
            end
        end
    end

    always @(posedge aclk) begin : check
        light_cmd_t want;
        light_cmd_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_action, m_brightness, m_led_lit, m_window_average};
            if (pending_cmds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result at %0t: action %0d brightness %0d led %0d avg %0d",
                             $time, got.action, got.brightness, got.led_lit, got.average);
                end
            end else begin
                want = pending_cmds.pop_front();
                if (got.action !== want.action || got.brightness !== want.brightness ||
                    got.led_lit !== want.led_lit || got.average !== want.average) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t: expected action %0d brightness %0d",
                                 $time, want.action, want.brightness);
                        $display("    expected led %0d avg %0d", want.led_lit, want.average);
                        $display("    got action %0d brightness %0d led %0d avg %0d",
                                 got.action, got.brightness, got.led_lit, got.average);
                    end
                end
            end
        end
    end

    initial begin
        foreach (ring[i]) begin
            ring[i] = '0;
        end
        wpos = 0;
        filled = 1'b0;
        sum = 0;
        lim = '{dwbm_pkg::NEAR_LIMIT_RST, dwbm_pkg::FAR_LIMIT_RST,
                dwbm_pkg::BASE_BRIGHTNESS_RST, dwbm_pkg::LEVEL_STEP_RST,
                dwbm_pkg::LEVEL_CEILING_RST};
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        repeat (2) @(negedge aclk);
        test_reset_defaults();
        test_settings();
        test_backpressure();
        test_random();
        settle();
        repeat (10) @(negedge aclk);
        if (mismatches == 0 && pending_cmds.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
